// File: sv/intel_hex_record_parser_defines.svh
// Assertion macros shared by the Intel HEX record parser RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define IHEX_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain condition checked at every clock edge outside reset.
`define IHEX_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

// File: sv/ihex_pkg.sv
// Shared types and codes for the Intel HEX record parser.
// No dependencies; used by ihex_core and intel_hex_record_parser.
`default_nettype none

package ihex_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3a;

   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_EOF     = 8'h01;
   localparam logic [7:0] REC_EXT_SEG = 8'h02;
   localparam logic [7:0] REC_EXT_LIN = 8'h04;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_START = 2'd1;
   localparam logic [1:0] ERR_BAD_TYPE = 2'd2;
   localparam logic [1:0] ERR_BAD_HEX  = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [7:0]  data_byte;
      logic [7:0]  record_type;
      logic        checksum_ok;
      logic [1:0]  error_code;
   } res_type;

endpackage

`default_nettype wire

// File: sv/ihex_core.sv
// Character-level parser state for Intel HEX records; yields at most one result per character.
// Depends on ihex_pkg and intel_hex_record_parser_defines.svh.
`default_nettype none
`include "intel_hex_record_parser_defines.svh"

module ihex_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            take,
   input  wire logic [7:0]      char_in,
   output      logic            res_valid,
   output      ihex_pkg::res_type res
);
   import ihex_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST, PH_IDLE, PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CHK
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  nib_ff, nib_in;
   logic        have_nib_ff, have_nib_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] extv_ff, extv_in;
   logic [31:0] exto_ff, exto_in;
   logic        halted_ff, halted_in;

   logic [4:0]  hex;
   logic [7:0]  b;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   assign hex = hex_decode(char_in);
   assign b   = {nib_ff, hex[3:0]};

   always_comb begin
      phase_in    = phase_ff;
      nib_in      = nib_ff;
      have_nib_in = have_nib_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      addr_in     = addr_ff;
      kind_in     = kind_ff;
      sum_in      = sum_ff;
      extv_in     = extv_ff;
      exto_in     = exto_ff;
      halted_in   = halted_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (take && !halted_ff) begin
         unique case (phase_ff) inside
            PH_FIRST, PH_IDLE: begin
               if (char_in == CHAR_COLON) begin
                  phase_in    = PH_LEN;
                  nib_in      = 4'd0;
                  have_nib_in = 1'b0;
                  idx_in      = 8'd0;
                  len_in      = 8'd0;
                  addr_in     = 16'd0;
                  kind_in     = 8'd0;
                  sum_in      = 8'd0;
                  extv_in     = 16'd0;
               end else if (phase_ff == PH_FIRST) begin
                  halted_in       = 1'b1;
                  res_valid       = 1'b1;
                  res.kind        = KIND_STATUS;
                  res.error_code  = ERR_NO_START;
               end
            end
            PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_CHK: begin
               if (!hex[4]) begin
                  halted_in       = 1'b1;
                  res_valid       = 1'b1;
                  res.kind        = KIND_STATUS;
                  res.record_type = kind_ff;
                  res.error_code  = ERR_BAD_HEX;
               end else if (!have_nib_ff) begin
                  nib_in      = hex[3:0];
                  have_nib_in = 1'b1;
               end else begin
                  have_nib_in = 1'b0;
                  nib_in      = 4'd0;
                  sum_in      = sum_ff + b;
                  unique case (phase_ff) inside
                     PH_LEN: begin
                        len_in   = b;
                        idx_in   = 8'd0;
                        phase_in = PH_ADDR;
                     end
                     PH_ADDR: begin
                        addr_in = {addr_ff[7:0], b};
                        if (idx_ff != 8'd0) begin
                           idx_in   = 8'd0;
                           phase_in = PH_TYPE;
                        end else begin
                           idx_in = 8'd1;
                        end
                     end
                     PH_TYPE: begin
                        kind_in = b;
                        if (b != REC_DATA && b != REC_EOF && b != REC_EXT_SEG
                            && b != REC_EXT_LIN) begin
                           halted_in       = 1'b1;
                           res_valid       = 1'b1;
                           res.kind        = KIND_STATUS;
                           res.record_type = b;
                           res.error_code  = ERR_BAD_TYPE;
                        end else begin
                           idx_in   = 8'd0;
                           phase_in = (len_ff != 8'd0) ? PH_DATA : PH_CHK;
                        end
                     end
                     PH_DATA: begin
                        if (kind_ff == REC_DATA) begin
                           res_valid     = 1'b1;
                           res.kind      = KIND_DATA;
                           res.address   = exto_ff + {16'd0, addr_ff} + {24'd0, idx_ff};
                           res.data_byte = b;
                        end else if ((kind_ff == REC_EXT_SEG || kind_ff == REC_EXT_LIN)
                                     && idx_ff < 8'd2) begin
                           extv_in = {extv_ff[7:0], b};
                        end
                        idx_in = idx_ff + 8'd1;
                        if (idx_in >= len_ff) begin
                           phase_in = PH_CHK;
                        end
                     end
                     default: begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_STATUS;
                        res.record_type = kind_ff;
                        res.checksum_ok = (sum_in == 8'd0);
                        if (kind_ff == REC_EXT_SEG) begin
                           exto_in = {12'd0, extv_ff, 4'd0};
                        end else if (kind_ff == REC_EXT_LIN) begin
                           exto_in = {extv_ff, 16'd0};
                        end else if (kind_ff == REC_EOF) begin
                           halted_in = 1'b1;
                        end
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         nib_ff      <= 4'd0;
         have_nib_ff <= 1'b0;
         idx_ff      <= 8'd0;
         len_ff      <= 8'd0;
         addr_ff     <= 16'd0;
         kind_ff     <= 8'd0;
         sum_ff      <= 8'd0;
         extv_ff     <= 16'd0;
         exto_ff     <= 32'd0;
         halted_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         nib_ff      <= nib_in;
         have_nib_ff <= have_nib_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         addr_ff     <= addr_in;
         kind_ff     <= kind_in;
         sum_ff      <= sum_in;
         extv_ff     <= extv_in;
         exto_ff     <= exto_in;
         halted_ff   <= halted_in;
      end
   end

   `IHEX_ASSERT_HOLDS(a_halted_silent, clock, reset, !(halted_ff && res_valid),
      "result produced while halted")
   `IHEX_ASSERT(a_error_halts, clock, reset,
      (res_valid && res.error_code != ERR_NONE) |=> halted_ff,
      "error status did not halt the parser")
   `IHEX_ASSERT(a_data_only_in_data, clock, reset,
      (res_valid && res.kind == KIND_DATA) |-> (phase_ff == PH_DATA && kind_ff == REC_DATA),
      "data result outside a data record")

endmodule

`default_nettype wire

// File: sv/intel_hex_record_parser.sv
// Intel HEX record parser top level: request channel, parser core, result register and skid stage.
// Depends on ihex_pkg, ihex_core and intel_hex_record_parser_defines.svh.
//
// Usage:
//   req_* carries one ASCII character per transaction (req_char_in).
//   rsp_* carries at most one result per character: a data byte with its full
//   32-bit address, or an end-of-record / error status.
//   Result path: the core is combinational; an accepted character's result is
//   registered in the output register, or in the skid stage if that is held.
//   Throughput: one character per cycle while req_stall is low; the parser
//   state is updated in the same cycle the character is accepted.
//   Stall: results sit in an output register backed by a one-entry skid stage.
//   While the receiver stalls, input keeps flowing until the skid stage holds
//   a result; req_stall is then raised until the output register drains.
//   Reset: synchronous, active high; clears the parser to wait for the first
//   ':' and empties the output register and the skid stage.
//   After an end-of-file record or any error the parser halts and accepts
//   characters silently until the next reset.
`default_nettype none
`include "intel_hex_record_parser_defines.svh"

module intel_hex_record_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_char_in,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_kind,
   output      logic [31:0] rsp_address,
   output      logic [7:0]  rsp_data_byte,
   output      logic [7:0]  rsp_record_type,
   output      logic        rsp_checksum_ok,
   output      logic [1:0]  rsp_error_code
);
   import ihex_pkg::*;

   logic    accept;
   logic    core_valid;
   res_type core_res;

   logic    out_valid_ff, out_valid_in;
   res_type out_ff, out_in;
   logic    skid_full_ff, skid_full_in;
   res_type skid_ff, skid_in;
   logic    out_taken;

   assign req_stall = skid_full_ff;
   assign accept    = req_valid && !skid_full_ff;
   assign out_taken = out_valid_ff && !rsp_stall;

   ihex_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (accept),
      .char_in   (req_char_in),
      .res_valid (core_valid),
      .res       (core_res)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      skid_full_in = skid_full_ff;
      skid_in      = skid_ff;
      if (skid_full_ff) begin
         if (out_taken) begin
            out_in       = skid_ff;
            skid_full_in = 1'b0;
         end
      end else if (core_valid) begin
         if (!out_valid_ff || out_taken) begin
            out_in       = core_res;
            out_valid_in = 1'b1;
         end else begin
            skid_in      = core_res;
            skid_full_in = 1'b1;
         end
      end else if (out_taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_address     = out_ff.address;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_record_type = out_ff.record_type;
   assign rsp_checksum_ok = out_ff.checksum_ok;
   assign rsp_error_code  = out_ff.error_code;

   `IHEX_ASSERT_HOLDS(a_skid_behind_out, clock, reset, !(skid_full_ff && !out_valid_ff),
      "skid stage full with empty output register")
   `IHEX_ASSERT(a_skid_fill, clock, reset,
      (core_valid && out_valid_ff && rsp_stall) |=> skid_full_ff,
      "stalled result not parked in skid stage")
   `IHEX_ASSERT(a_skid_drain, clock, reset,
      (skid_full_ff && !rsp_stall) |=> (out_valid_ff && !skid_full_ff),
      "skid stage not drained into output register")

endmodule

`default_nettype wire

// File: tb/sv/intel_hex_record_parser_test.sv
// Self-checking testbench for intel_hex_record_parser: feeds Intel HEX text one character at a
// time and checks every result against a behavioral parser kept in a scoreboard class.
// Depends on ihex_pkg and the intel_hex_record_parser RTL.

module intel_hex_record_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ihex_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT      = 4000;
   localparam int DRAIN_CYCLES     = 16;
   localparam int RANDOM_CHARS     = 1400;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;

   typedef logic [7:0] byte_q_type[$];
   typedef enum int {END_EOF, END_BAD_TYPE, END_BAD_HEX} run_end_type;

   class hex_record_predictor;
      typedef enum logic [2:0] {
         WAIT_START, BETWEEN, GET_LEN, GET_ADDR, GET_TYPE, GET_DATA, GET_SUM
      } parse_phase_type;

      parse_phase_type phase;
      logic [3:0]   nibble;
      bit           have_nibble;
      logic [7:0]   byte_idx;
      logic [7:0]   rec_len;
      logic [15:0]  rec_addr;
      logic [7:0]   rec_type;
      logic [7:0]   sum;
      logic [15:0]  ext_value;
      logic [31:0]  ext_offset;
      bit           halted;
      res_type      expected_q[$];
      int           failures;

      function new();
         phase       = WAIT_START;
         nibble      = '0;
         have_nibble = 1'b0;
         byte_idx    = '0;
         rec_len     = '0;
         rec_addr    = '0;
         rec_type    = '0;
         sum         = '0;
         ext_value   = '0;
         ext_offset  = '0;
         halted      = 1'b0;
         failures    = 0;
      endfunction

      static function int digit_value(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         return -1;
      endfunction

      function void start_record();
         phase       = GET_LEN;
         nibble      = '0;
         have_nibble = 1'b0;
         byte_idx    = '0;
         rec_len     = '0;
         rec_addr    = '0;
         rec_type    = '0;
         sum         = '0;
         ext_value   = '0;
      endfunction

      function void push_status(logic [7:0] t, logic ok, logic [1:0] err);
         res_type r;
         r             = '0;
         r.kind        = KIND_STATUS;
         r.record_type = t;
         r.checksum_ok = ok;
         r.error_code  = err;
         expected_q.push_back(r);
      endfunction

      // One accepted character: update the parse state and queue any result.
      function void note_char(logic [7:0] c);
         int         d;
         logic [7:0] b;
         res_type    r;
         if (halted) return;
         if (phase == WAIT_START) begin
            if (c == CHAR_COLON) begin
               start_record();
            end else begin
               halted = 1'b1;
               push_status(8'h00, 1'b0, ERR_NO_START);
            end
            return;
         end
         if (phase == BETWEEN) begin
            if (c == CHAR_COLON) start_record();
            return;
         end
         d = digit_value(c);
         if (d < 0) begin
            halted = 1'b1;
            push_status(rec_type, 1'b0, ERR_BAD_HEX);
            return;
         end
         if (!have_nibble) begin
            nibble      = d[3:0];
            have_nibble = 1'b1;
            return;
         end
         b           = {nibble, d[3:0]};
         have_nibble = 1'b0;
         nibble      = '0;
         sum         = sum + b;
         case (phase)
            GET_LEN: begin
               rec_len  = b;
               byte_idx = '0;
               phase    = GET_ADDR;
            end
            GET_ADDR: begin
               rec_addr = {rec_addr[7:0], b};
               byte_idx = byte_idx + 8'd1;
               if (byte_idx >= 8'd2) begin
                  byte_idx = '0;
                  phase    = GET_TYPE;
               end
            end
            GET_TYPE: begin
               rec_type = b;
               if (b != REC_DATA && b != REC_EOF && b != REC_EXT_SEG && b != REC_EXT_LIN) begin
                  halted = 1'b1;
                  push_status(rec_type, 1'b0, ERR_BAD_TYPE);
               end else begin
                  byte_idx = '0;
                  phase    = (rec_len != 8'd0) ? GET_DATA : GET_SUM;
               end
            end
            GET_DATA: begin
               if (rec_type == REC_DATA) begin
                  r           = '0;
                  r.kind      = KIND_DATA;
                  r.address   = ext_offset + {16'h0000, rec_addr} + {24'h000000, byte_idx};
                  r.data_byte = b;
                  expected_q.push_back(r);
               end else if ((rec_type == REC_EXT_SEG || rec_type == REC_EXT_LIN)
                            && byte_idx < 8'd2) begin
                  ext_value = {ext_value[7:0], b};
               end
               byte_idx = byte_idx + 8'd1;
               if (byte_idx >= rec_len) phase = GET_SUM;
            end
            default: begin
               push_status(rec_type, sum == 8'h00, ERR_NONE);
               if (rec_type == REC_EXT_SEG)
                  ext_offset = {12'h000, ext_value, 4'h0};
               else if (rec_type == REC_EXT_LIN)
                  ext_offset = {ext_value, 16'h0000};
               else if (rec_type == REC_EOF)
                  halted = 1'b1;
               phase = BETWEEN;
            end
         endcase
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            failures++;
         end
      endfunction

      function void check_result(res_type got);
         res_type want;
         if (expected_q.size() == 0) begin
            $error("result with none expected: kind %0d address 0x%0h data 0x%0h",
                   got.kind, got.address, got.data_byte);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         check_field("kind", want.kind, got.kind);
         check_field("address", want.address, got.address);
         check_field("data_byte", want.data_byte, got.data_byte);
         check_field("record_type", want.record_type, got.record_type);
         check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
         check_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [31:0] rsp_address;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_record_type;
   logic        rsp_checksum_ok;
   logic [1:0]  rsp_error_code;

   hex_record_predictor parser_model = new();

   int snd_idle_pct;
   int rcv_idle_pct;
   bit long_hold_req;
   int chars_sent;
   int cut_countdown = -1;
   bit record_cut;
   int quiet_cycles;

   intel_hex_record_parser u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_address     (rsp_address),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_record_type (rsp_record_type),
      .rsp_checksum_ok (rsp_checksum_ok),
      .rsp_error_code  (rsp_error_code)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return CH_ZERO + {4'h0, n};
      return (($urandom_range(0, 1) != 0) ? CH_UPPER_A : CH_LOWER_A) + {4'h0, n} - 8'd10;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CHAR_COLON);
      return c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0: c = CHAR_COLON;
         1: c = CH_LF;
         2: c = CH_CR;
         default: begin
            do c = 8'($urandom); while (hex_record_predictor::digit_value(c) >= 0);
         end
      endcase
      return c;
   endfunction

   function automatic byte_q_type random_payload(int n);
      byte_q_type q;
      for (int i = 0; i < n; i++) q.push_back(8'($urandom));
      return q;
   endfunction

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parser_model.note_char(c);
      chars_sent++;
   endtask

   // A cut replaces one digit by a non-hex character and drops the rest of the record.
   task automatic send_digit(input logic [3:0] n);
      if (record_cut) return;
      if (cut_countdown == 0) begin
         send_char(non_hex_char());
         record_cut = 1'b1;
         return;
      end
      if (cut_countdown > 0) cut_countdown--;
      send_char(hex_char(n));
   endtask

   task automatic send_hex_byte(input logic [7:0] b);
      send_digit(b[7:4]);
      send_digit(b[3:0]);
   endtask

   task automatic send_gap();
      int n;
      n = $urandom_range(0, 3);
      repeat (n) send_char(($urandom_range(0, 1) != 0) ? CH_LF : noise_char());
   endtask

   task automatic send_record(input logic [15:0] addr, input logic [7:0] rtype,
                              input byte_q_type bytes_q, input bit bad_sum);
      logic [7:0] len;
      logic [7:0] total;
      len   = 8'(bytes_q.size());
      total = len + addr[15:8] + addr[7:0] + rtype;
      send_char(CHAR_COLON);
      send_hex_byte(len);
      send_hex_byte(addr[15:8]);
      send_hex_byte(addr[7:0]);
      send_hex_byte(rtype);
      foreach (bytes_q[i]) begin
         send_hex_byte(bytes_q[i]);
         total = total + bytes_q[i];
      end
      total = -total;
      if (bad_sum) total = total + 8'($urandom_range(1, 255));
      send_hex_byte(total);
      send_gap();
   endtask

   task automatic send_random_record();
      byte_q_type pl;
      logic [7:0] rtype;
      logic [7:0] fill;
      logic [15:0] addr;
      int         n;
      int         pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
         addr = 16'hfff8 + 16'($urandom_range(0, 7));
      else
         addr = 16'($urandom);
      if (pick < 72) begin
         rtype = REC_DATA;
         n     = ($urandom_range(0, 63) == 0) ? 255 : $urandom_range(0, 16);
      end else begin
         rtype = (pick < 86) ? REC_EXT_LIN : REC_EXT_SEG;
         n     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2;
      end
      pl = random_payload(n);
      if (rtype != REC_DATA && n >= 2 && $urandom_range(0, 3) == 0) begin
         fill  = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
         pl[0] = fill;
         pl[1] = fill;
      end
      send_record(addr, rtype, pl, $urandom_range(0, 9) == 0);
   endtask

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         parser_model.check_result({rsp_kind, rsp_address, rsp_data_byte, rsp_record_type,
                                    rsp_checksum_ok, rsp_error_code});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("** intel_hex_record_parser: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      byte_q_type  pl;
      logic [7:0]  c;
      run_end_type ending;
      int          stop_at;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_char_in  = 8'h00;
      snd_idle_pct = 11;
      rcv_idle_pct = 46;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Occasionally the stream opens without a start marker; all later input is then ignored.
      if ($urandom_range(0, 7) == 0) send_char(noise_char());

      pl = {8'h00, 8'hff};
      send_record(16'h0000, REC_DATA, pl, 1'b0);
      pl = {8'hff, 8'hff};
      send_record(16'h0000, REC_EXT_LIN, pl, 1'b0);
      pl = {8'h5a, 8'ha5};
      send_record(16'hffff, REC_DATA, pl, 1'b0);
      pl = {8'hff, 8'hff};
      send_record(16'h0000, REC_EXT_SEG, pl, 1'b1);
      pl = {8'h01};
      send_record(16'h1234, REC_DATA, pl, 1'b0);
      pl = {8'hab};
      send_record(16'h0000, REC_EXT_SEG, pl, 1'b0);
      pl = {8'h12, 8'h34, 8'h56};
      send_record(16'h0000, REC_EXT_LIN, pl, 1'b0);
      pl.delete();
      send_record(16'hffff, REC_EXT_LIN, pl, 1'b0);
      send_record(16'h8000, REC_DATA, pl, 1'b0);

      stop_at = chars_sent;
      for (int ph = 0; ph < 3; ph++) begin
         snd_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 46 : 0;
         rcv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 11 : 0;
         if (ph == 2) long_hold_req = 1'b1;
         stop_at = stop_at + RANDOM_CHARS / 3;
         while (chars_sent < stop_at) send_random_record();
      end

      // The run ends on one halting record, then checks that later text is ignored.
      ending = run_end_type'($urandom_range(0, 2));
      case (ending)
         END_EOF: begin
            pl = random_payload($urandom_range(0, 2));
            send_record(16'($urandom), REC_EOF, pl, $urandom_range(0, 3) == 0);
         end
         END_BAD_TYPE: begin
            do c = 8'($urandom);
            while (c == REC_DATA || c == REC_EOF || c == REC_EXT_SEG || c == REC_EXT_LIN);
            pl = random_payload($urandom_range(0, 3));
            send_record(16'($urandom), c, pl, 1'b0);
         end
         default: begin
            pl            = random_payload(3);
            cut_countdown = $urandom_range(0, 15);
            record_cut    = 1'b0;
            send_record(16'($urandom), REC_DATA, pl, 1'b0);
         end
      endcase
      cut_countdown = -1;
      record_cut    = 1'b0;
      repeat (8) send_char(($urandom_range(0, 3) == 0) ? CHAR_COLON : noise_char());
      pl = random_payload(2);
      send_record(16'($urandom), REC_DATA, pl, 1'b0);
      req_valid <= 1'b0;

      while (parser_model.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (parser_model.failures == 0 && parser_model.expected_q.size() == 0)
         $display("** intel_hex_record_parser: PASSED **");
      else
         $display("** intel_hex_record_parser: FAILED **");
      $finish;
   end

endmodule
